/* rtl/fpasc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpasc_pkg
// Shared types and constants for the single-precision add/sub/compare/convert
// pipeline.
// ----------------------------------------------------------------------------
package fpasc_pkg;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_CMP  = 3'd2,
    CMD_CVT  = 3'd3,
    CMD_UNO  = 3'd4
  } cmd_t;

  localparam logic [31:0] MAG_MASK  = 32'h7fff_ffff;
  localparam logic [31:0] QNAN_BITS = 32'h7fc0_0000;
  localparam logic [31:0] INF_BITS  = 32'h7f80_0000;
  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
  localparam logic [7:0]  EXP_ONES  = 8'hff;
  localparam logic [7:0]  EXP_BIAS  = 8'd127;

  // Results that bypass the adder datapath (special cases, cmp, cvt, nan).
  typedef struct packed {
    logic        done;      // final sum already known
    logic [31:0] sum;
    logic [31:0] ival;
    logic [1:0]  ord;
    logic        uno;
  } side_t;

endpackage
`default_nettype wire

/* rtl/fpasc_align.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpasc_align
// Stage one: swap, special cases, alignment shift with sticky, plus the
// compare, convert and NaN results.
// ----------------------------------------------------------------------------
module fpasc_align (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          vld_in,
  input  wire logic [2:0]    cmd,
  input  wire logic [31:0]   op_a,
  input  wire logic [31:0]   op_b,
  output logic               vld_r,
  output logic               sx_r,
  output logic               sub_r,
  output logic [8:0]         ee_r,
  output logic [26:0]        gx_r,
  output logic [26:0]        gy_r,
  output fpasc_pkg::side_t   side_r
);
  import fpasc_pkg::*;

  logic [31:0] b_eff, x, y;
  logic [7:0]  ex, ey, pxe, pye, exp_diff;
  logic [22:0] mx, my;
  logic [26:0] gx, gy, gy_sh, lost;
  logic        sx, sy;
  side_t       side;
  logic [7:0]  ea, pa;
  logic [23:0] siga;
  logic [31:0] r;
  logic [31:0] ma, mb;

  always_comb begin
    b_eff = (cmd == CMD_SUB) ? (op_b ^ SIGN_BIT) : op_b;
    if ((op_a & MAG_MASK) < (b_eff & MAG_MASK)) begin
      x = b_eff; y = op_a;
    end else begin
      x = op_a; y = b_eff;
    end
    sx = x[31]; sy = y[31];
    ex = x[30:23]; ey = y[30:23];
    mx = x[22:0]; my = y[22:0];
    gx = {(ex != 8'd0), mx, 3'b000};
    gy = {(ey != 8'd0), my, 3'b000};
    pxe = (ex != 8'd0) ? ex : 8'd1;
    pye = (ey != 8'd0) ? ey : 8'd1;
    exp_diff = pxe - pye;
    lost = 27'd0;
    if (exp_diff >= 8'd27) begin
      gy_sh = {26'd0, (gy != 27'd0)};
    end else begin
      lost  = gy & ((27'd1 << exp_diff[4:0]) - 27'd1);
      gy_sh = (gy >> exp_diff[4:0]) | {26'd0, (lost != 27'd0)};
    end

    side = '0;
    if (cmd == CMD_ADD || cmd == CMD_SUB) begin
      if (ex == EXP_ONES) begin
        side.done = 1'b1;
        side.sum  = (mx == 23'd0 && ey == EXP_ONES && my == 23'd0 && sx != sy)
                    ? QNAN_BITS : x;
      end else if ((y & MAG_MASK) == 32'd0) begin
        side.done = 1'b1;
        if ((x & MAG_MASK) == 32'd0) side.sum = (sx & sy) ? SIGN_BIT : 32'd0;
        else side.sum = x;
      end
    end else begin
      side.done = 1'b1;
    end

    ma = op_a & MAG_MASK; mb = op_b & MAG_MASK;
    if (cmd == CMD_CMP && ((op_a | op_b) & MAG_MASK) != 32'd0) begin
      if (op_a[31] != op_b[31]) side.ord = op_a[31] ? 2'b11 : 2'b01;
      else if (ma == mb) side.ord = 2'b00;
      else if ((ma < mb) ^ op_a[31]) side.ord = 2'b11;
      else side.ord = 2'b01;
    end

    ea = op_a[30:23];
    pa = ea - EXP_BIAS;
    siga = {1'b1, op_a[22:0]};
    r = 32'd0;
    if (cmd == CMD_CVT && ea != 8'd0) begin
      if (ea == EXP_ONES || ea >= 8'd158) begin
        side.ival = op_a[31] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else if (ea >= EXP_BIAS) begin
        if (pa >= 8'd23) r = {8'd0, siga} << (pa[4:0] - 5'd23);
        else r = {8'd0, siga} >> (5'd23 - pa[4:0]);
        side.ival = op_a[31] ? (32'd0 - r) : r;
      end
    end

    if (cmd == CMD_UNO) begin
      side.uno = (op_a[30:23] == EXP_ONES && op_a[22:0] != 23'd0) ||
                 (op_b[30:23] == EXP_ONES && op_b[22:0] != 23'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_in;
    sx_r   <= sx;
    sub_r  <= (sx != sy);
    ee_r   <= {1'b0, pxe};
    gx_r   <= gx;
    gy_r   <= gy_sh;
    side_r <= side;
  end

endmodule
`default_nettype wire

/* rtl/fpasc_addnorm.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpasc_addnorm
// Stage two: significand add or subtract and leading-one normalization.
// ----------------------------------------------------------------------------
module fpasc_addnorm (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          vld_in,
  input  wire logic          sx,
  input  wire logic          sub,
  input  wire logic [8:0]    ee,
  input  wire logic [26:0]   gx,
  input  wire logic [26:0]   gy,
  input  fpasc_pkg::side_t   side,
  output logic               vld_r,
  output logic               sx_r,
  output logic signed [9:0]  ee_r,
  output logic [26:0]        acc_r,
  output fpasc_pkg::side_t   side_r
);
  import fpasc_pkg::*;

  logic [27:0]        s;
  logic [26:0]        acc;
  logic signed [9:0]  e;
  logic [4:0]         lz;
  side_t              sd;

  always_comb begin
    sd  = side;
    e   = $signed({1'b0, ee});
    acc = 27'd0;
    lz  = 5'd0;
    if (!sub) begin
      s = {1'b0, gx} + {1'b0, gy};
      if (s[27]) begin
        acc = s[27:1] | {26'd0, s[0]};
        e   = e + 10'sd1;
      end else begin
        acc = s[26:0];
      end
    end else begin
      s = {1'b0, gx} - {1'b0, gy};
      if (s[26:0] == 27'd0) begin
        if (!sd.done) begin
          sd.done = 1'b1;
          sd.sum  = 32'd0;
        end
      end
      for (int i = 0; i < 27; i++) begin
        if (s[i]) lz = 5'(26 - i);
      end
      acc = s[26:0] << lz;
      e   = e - $signed({5'd0, lz});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_in;
    sx_r   <= sx;
    ee_r   <= e;
    acc_r  <= acc;
    side_r <= sd;
  end

endmodule
`default_nettype wire

/* rtl/fpasc_round.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpasc_round
// Stage three: round to nearest even, overflow, subnormal denormalization and packing.
// ----------------------------------------------------------------------------
module fpasc_round (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          vld_in,
  input  wire logic          sx,
  input  wire logic signed [9:0] ee,
  input  wire logic [26:0]   acc,
  input  fpasc_pkg::side_t   side,
  output logic               vld_r,
  output logic [31:0]        sum_r,
  output logic [31:0]        ival_r,
  output logic [1:0]         ord_r,
  output logic               uno_r
);
  import fpasc_pkg::*;

  logic [2:0]        grs;
  logic [24:0]       sig;
  logic signed [9:0] e, sh;
  logic [31:0]       packed_v;

  always_comb begin
    grs = acc[2:0];
    sig = {1'b0, acc[26:3]};
    e   = ee;
    if (grs > 3'd4 || (grs == 3'd4 && sig[0])) begin
      sig = sig + 25'd1;
      if (sig[24]) begin
        sig = sig >> 1;
        e   = e + 10'sd1;
      end
    end
    sh = 10'sd1 - e;
    if (e >= 10'sd255) begin
      packed_v = {sx, INF_BITS[30:0]};
    end else if (e <= 10'sd0) begin
      if (sh >= 10'sd24) packed_v = {sx, 31'd0};
      else packed_v = {sx, 8'd0, 23'(sig[23:0] >> sh[4:0])};
    end else begin
      packed_v = {sx, e[7:0], sig[22:0]};
    end
    if (side.done) packed_v = side.sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_in;
    sum_r  <= packed_v;
    ival_r <= side.ival;
    ord_r  <= side.ord;
    uno_r  <= side.uno;
  end

endmodule
`default_nettype wire

/* rtl/fp32_add_sub_cmp_convert_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fp32_add_sub_cmp_convert_core
// Single-precision add/subtract, compare, float-to-int32 and NaN test.
// ----------------------------------------------------------------------------
// Usage: raise start with in_cmd, in_op_a and in_op_b; the item is taken at
// that edge since busy is always low (the pipeline never stalls).
// A new item may be issued every cycle: throughput is one item per cycle.
// The result passes through the align, add/normalize and round stage
// registers and appears on the out_ ports with out_valid high, for one cycle only.
// Stage one swaps operands, resolves special cases and aligns; stage two
// adds or subtracts and normalizes; stage three rounds and packs.
// Compare, convert and NaN results are formed in stage one and ride along.
// Fields that a command does not produce read zero; unknown commands give
// an item with all fields zero.
// Reset (rst_n low, synchronous) clears the valid bits of every stage, so
// items in flight are dropped. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
module fp32_add_sub_cmp_convert_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_cmd,
  input  wire logic [31:0]        in_op_a,
  input  wire logic [31:0]        in_op_b,
  output logic                    out_valid,
  output logic [31:0]             out_sum_bits,
  output logic signed [31:0]      out_int_value,
  output logic signed [1:0]       out_order,
  output logic                    out_unordered
);
  import fpasc_pkg::*;

  logic              v1, sx1, sub1;
  logic [8:0]        ee1;
  logic [26:0]       gx1, gy1;
  side_t             sd1;
  logic              v2, sx2;
  logic signed [9:0] ee2;
  logic [26:0]       acc2;
  side_t             sd2;
  logic [31:0]       ival;
  logic [1:0]        ord;

  assign busy = 1'b0;

  fpasc_align u_align (
    .clk(clk), .rst_n(rst_n), .vld_in(start & ~busy), .cmd(in_cmd),
    .op_a(in_op_a), .op_b(in_op_b), .vld_r(v1), .sx_r(sx1), .sub_r(sub1),
    .ee_r(ee1), .gx_r(gx1), .gy_r(gy1), .side_r(sd1)
  );

  fpasc_addnorm u_addnorm (
    .clk(clk), .rst_n(rst_n), .vld_in(v1), .sx(sx1), .sub(sub1), .ee(ee1),
    .gx(gx1), .gy(gy1), .side(sd1), .vld_r(v2), .sx_r(sx2), .ee_r(ee2),
    .acc_r(acc2), .side_r(sd2)
  );

  fpasc_round u_round (
    .clk(clk), .rst_n(rst_n), .vld_in(v2), .sx(sx2), .ee(ee2), .acc(acc2),
    .side(sd2), .vld_r(out_valid), .sum_r(out_sum_bits), .ival_r(ival),
    .ord_r(ord), .uno_r(out_unordered)
  );

  assign out_int_value = $signed(ival);
  assign out_order     = $signed(ord);

endmodule
`default_nettype wire

/* sim/fp32_add_sub_cmp_convert_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fp32_add_sub_cmp_convert_checker
// Watches the command and result channels of the single-precision core,
// predicts every result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module fp32_add_sub_cmp_convert_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [2:0]         in_cmd,
  input  wire logic [31:0]        in_op_a,
  input  wire logic [31:0]        in_op_b,
  input  wire logic               out_valid,
  input  wire logic [31:0]        out_sum_bits,
  input  wire logic signed [31:0] out_int_value,
  input  wire logic signed [1:0]  out_order,
  input  wire logic               out_unordered,
  output int                      fail_count,
  output int                      pending,
  output int                      done_count
);
  import fpasc_pkg::*;

  typedef struct packed {
    logic [31:0] sum;
    logic [31:0] ival;
    logic [1:0]  ord;
    logic        uno;
  } fp_result_t;

  fp_result_t result_queue[$];

  function automatic logic [31:0] round_and_pack(logic sgn, int ex, logic [31:0] acc);
    logic [2:0]  grs;
    logic [31:0] sig;
    int          sh;
    grs = acc[2:0];
    sig = acc >> 3;
    if (grs > 3'd4 || (grs == 3'd4 && sig[0])) begin
      sig = sig + 1;
      if (sig[24]) begin
        sig = sig >> 1;
        ex  = ex + 1;
      end
    end
    if (ex >= 255) return {sgn, INF_BITS[30:0]};
    if (ex <= 0) begin
      sh = 1 - ex;
      if (sh >= 24) return {sgn, 31'd0};
      sig = sig >> sh;
      return {sgn, 8'd0, sig[22:0]};
    end
    return {sgn, ex[7:0], sig[22:0]};
  endfunction

  function automatic logic [31:0] fp_sum(logic [31:0] x, logic [31:0] y);
    logic [31:0] t, gx, gy, acc;
    logic [7:0]  ex, ey;
    int          px, py, exp_diff, ee;
    if ((x & MAG_MASK) < (y & MAG_MASK)) begin
      t = x; x = y; y = t;
    end
    ex = x[30:23];
    ey = y[30:23];
    if (ex == EXP_ONES) begin
      if (x[22:0] == 0 && ey == EXP_ONES && y[22:0] == 0 && x[31] != y[31])
        return QNAN_BITS;
      return x;
    end
    if ((y & MAG_MASK) == 0) begin
      if ((x & MAG_MASK) == 0) return (x[31] & y[31]) ? SIGN_BIT : 32'd0;
      return x;
    end
    gx = {5'd0, ex != 0, x[22:0], 3'd0};
    gy = {5'd0, ey != 0, y[22:0], 3'd0};
    px = (ex != 0) ? int'(ex) : 1;
    py = (ey != 0) ? int'(ey) : 1;
    exp_diff = px - py;
    if (exp_diff > 0) begin
      if (exp_diff >= 32) gy = (gy != 0) ? 32'd1 : 32'd0;
      else gy = (gy >> exp_diff) | ((gy & ((32'd1 << exp_diff) - 1)) != 0);
    end
    ee = px;
    if (x[31] == y[31]) begin
      acc = gx + gy;
      if (acc[27]) begin
        acc = (acc >> 1) | acc[0];
        ee++;
      end
    end else begin
      acc = gx - gy;
      if (acc == 0) return 32'd0;
      while (!acc[26]) begin
        acc = acc << 1;
        ee--;
      end
    end
    return round_and_pack(x[31], ee, acc);
  endfunction

  function automatic logic [1:0] fp_order(logic [31:0] x, logic [31:0] y);
    int c;
    if (((x | y) & MAG_MASK) == 0) return 2'd0;
    if (x[31] != y[31]) return x[31] ? 2'b11 : 2'b01;
    c = ((x & MAG_MASK) < (y & MAG_MASK)) ? -1 :
        (((x & MAG_MASK) > (y & MAG_MASK)) ? 1 : 0);
    if (x[31]) c = -c;
    return c[1:0];
  endfunction

  function automatic logic [31:0] fp_to_int(logic [31:0] x);
    int          p;
    logic [31:0] sig, r;
    if (x[30:23] == 0) return 32'd0;
    if (x[30:23] == EXP_ONES) return x[31] ? 32'h8000_0000 : 32'h7fff_ffff;
    p = int'(x[30:23]) - int'(EXP_BIAS);
    if (p < 0) return 32'd0;
    if (p >= 31) return x[31] ? 32'h8000_0000 : 32'h7fff_ffff;
    sig = {9'd1, x[22:0]};
    r = (p >= 23) ? (sig << (p - 23)) : (sig >> (23 - p));
    return x[31] ? -r : r;
  endfunction

  function automatic logic is_nan(logic [31:0] x);
    return x[30:23] == EXP_ONES && x[22:0] != 0;
  endfunction

  function automatic fp_result_t predict_result(logic [2:0] cmd, logic [31:0] a, logic [31:0] b);
    fp_result_t r;
    r = '0;
    case (cmd)
      CMD_ADD: r.sum  = fp_sum(a, b);
      CMD_SUB: r.sum  = fp_sum(a, b ^ SIGN_BIT);
      CMD_CMP: r.ord  = fp_order(a, b);
      CMD_CVT: r.ival = fp_to_int(a);
      CMD_UNO: r.uno  = is_nan(a) || is_nan(b);
      default: r = '0;
    endcase
    return r;
  endfunction

  assign pending = result_queue.size();

  initial begin
    fail_count = 0;
    done_count = 0;
  end

  always @(posedge clk) begin
    fp_result_t want;
    if (rst_n) begin
      if (start && !busy) result_queue.push_back(predict_result(in_cmd, in_op_a, in_op_b));
      if (out_valid) begin
        done_count++;
        if (result_queue.size() == 0) begin
          $error("unexpected result: sum_bits %h", out_sum_bits);
          fail_count++;
        end else begin
          want = result_queue.pop_front();
          if (out_sum_bits !== want.sum) begin
            $error("sum_bits: expected %h, got %h", want.sum, out_sum_bits);
            fail_count++;
          end
          if (out_int_value !== want.ival) begin
            $error("int_value: expected %h, got %h", want.ival, out_int_value);
            fail_count++;
          end
          if (out_order !== want.ord) begin
            $error("order: expected %b, got %b", want.ord, out_order);
            fail_count++;
          end
          if (out_unordered !== want.uno) begin
            $error("unordered: expected %b, got %b", want.uno, out_unordered);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

/* sim/fp32_add_sub_cmp_convert_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fp32_add_sub_cmp_convert_core_tb
// Drives directed and random commands into the single-precision core and
// lets the checker compare every result against its own prediction.
// ----------------------------------------------------------------------------
module fp32_add_sub_cmp_convert_core_tb;
  import fpasc_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_cmd;
  logic [31:0]        in_op_a;
  logic [31:0]        in_op_b;
  logic               out_valid;
  logic [31:0]        out_sum_bits;
  logic signed [31:0] out_int_value;
  logic signed [1:0]  out_order;
  logic               out_unordered;
  int                 fail_count;
  int                 pending;
  int                 done_count;
  int                 idle_cycles;
  int                 sent_count;
  int                 gap_percent;

  fp32_add_sub_cmp_convert_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_op_a(in_op_a), .in_op_b(in_op_b),
    .out_valid(out_valid), .out_sum_bits(out_sum_bits),
    .out_int_value(out_int_value), .out_order(out_order),
    .out_unordered(out_unordered)
  );

  fp32_add_sub_cmp_convert_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_op_a(in_op_a), .in_op_b(in_op_b),
    .out_valid(out_valid), .out_sum_bits(out_sum_bits),
    .out_int_value(out_int_value), .out_order(out_order),
    .out_unordered(out_unordered), .fail_count(fail_count),
    .pending(pending), .done_count(done_count)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The watchdog counts cycles with no accepted item on either channel.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("fp32_add_sub_cmp_convert_core_tb: errors");
      $finish;
    end
  end

  // Interesting operands: zeros, infinities, NaNs, subnormals, extremes.
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 11))
      0: v = {v[31], 31'd0};
      1: v = {v[31], INF_BITS[30:0]};
      2: v = {v[31], 8'hff, v[22:0] | 23'd1};
      3: v = {v[31], 8'd0, v[22:0]};
      4: v = {v[31], 8'($urandom_range(120, 160)), v[22:0]};
      5: v = {v[31], 8'($urandom_range(1, 3)), v[22:0]};
      6: v = {v[31], 8'($urandom_range(250, 254)), v[22:0]};
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Sends one item; each cycle before it idles with the gap probability,
  // then start holds until the item is accepted.
  task automatic send_item(logic [2:0] cmd, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(0, 99) < gap_percent) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_cmd  <= cmd;
    in_op_a <= a;
    in_op_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
  endtask

  // With the second operand a near copy of the first, subtraction cancels.
  task automatic send_random();
    logic [31:0] a, b;
    logic [2:0]  cmd;
    a = pick_operand();
    b = pick_operand();
    if ($urandom_range(0, 3) == 0) b = {$urandom_range(0, 1) == 1, a[30:2], 2'($urandom)};
    if ($urandom_range(0, 3) == 0) b[30:23] = a[30:23] - 8'($urandom_range(0, 30));
    cmd = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    send_item(cmd, a, b);
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_cmd      = CMD_ADD;
    in_op_a     = '0;
    in_op_b     = '0;
    idle_cycles = 0;
    sent_count  = 0;
    gap_percent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: signed zeros, inf minus inf, NaN, overflow, cancellation,
    // subnormals, conversion limits and the unknown commands.
    send_item(CMD_ADD, 32'h8000_0000, 32'h8000_0000);
    send_item(CMD_ADD, 32'h8000_0000, 32'h0000_0000);
    send_item(CMD_ADD, 32'h7f80_0000, 32'hff80_0000);
    send_item(CMD_SUB, 32'h7f80_0000, 32'h7f80_0000);
    send_item(CMD_ADD, 32'h7fc0_0001, 32'h3f80_0000);
    send_item(CMD_ADD, 32'h7f7f_ffff, 32'h7f7f_ffff);
    send_item(CMD_SUB, 32'h3f80_0000, 32'h3f80_0000);
    send_item(CMD_ADD, 32'h0000_0001, 32'h807f_ffff);
    send_item(CMD_ADD, 32'h0040_0000, 32'h0040_0000);
    send_item(CMD_SUB, 32'h0080_0000, 32'h0000_0001);
    send_item(CMD_ADD, 32'h3f80_0000, 32'h3380_0000);
    send_item(CMD_ADD, 32'h4b80_0000, 32'h0000_0001);
    send_item(CMD_CMP, 32'h8000_0000, 32'h0000_0000);
    send_item(CMD_CMP, 32'hbf80_0000, 32'h3f80_0000);
    send_item(CMD_CMP, 32'hc000_0000, 32'hbf80_0000);
    send_item(CMD_CMP, 32'h7fc0_0000, 32'h7f80_0000);
    send_item(CMD_CVT, 32'h4effffff, 32'hffff_ffff);
    send_item(CMD_CVT, 32'hcf00_0000, 32'h0);
    send_item(CMD_CVT, 32'h7fc0_0000, 32'h0);
    send_item(CMD_CVT, 32'hbf7f_ffff, 32'h0);
    send_item(CMD_CVT, 32'hc2f6_e979, 32'h0);
    send_item(CMD_UNO, 32'h3f80_0000, 32'hff80_0001);
    send_item(CMD_UNO, 32'hff80_0000, 32'h7f80_0000);
    send_item(3'd5, 32'hffff_ffff, 32'hffff_ffff);
    send_item(3'd7, 32'hffff_ffff, 32'hffff_ffff);

    // Random phases: light then heavy sender gaps, then back to back.
    gap_percent = 6;
    repeat (310) send_random();
    gap_percent = 61;
    repeat (310) send_random();
    gap_percent = 0;
    repeat (310) send_random();
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    $display("Sent %0d items, %0d results checked, covering all five commands,",
             sent_count, done_count);
    $display("special operands and unknown command codes.");
    if (fail_count == 0) $display("fp32_add_sub_cmp_convert_core_tb: clean");
    else $display("fp32_add_sub_cmp_convert_core_tb: errors");
    $finish;
  end

endmodule
